// ===== rtl/core/kprp_pkg.sv =====
package kprp_pkg;

    // Field widths
    localparam int NOTE_W  = 7;
    localparam int CHAN_W  = 4;
    localparam int VEL_W   = 7;
    localparam int TIME_W  = 32;
    localparam int FREQ_W  = 30;
    localparam int LEVEL_W = 17;

    // Opcodes carried in s_tuser
    localparam logic [1:0] OP_PRESS   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_FLUSH   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_DRUM_LIMIT   = 2'd0;
    localparam logic [1:0] CFG_DRUM_SHORT   = 2'd1;
    localparam logic [1:0] CFG_HOLD_DEFAULT = 2'd2;

    // Configuration reset values (microseconds)
    localparam logic [TIME_W-1:0] DRUM_LIMIT_RST   = 32'd500000;
    localparam logic [TIME_W-1:0] DRUM_SHORT_RST   = 32'd200000;
    localparam logic [TIME_W-1:0] HOLD_DEFAULT_RST = 32'd1000000;

    typedef enum logic [1:0] {
        STAT_NOTE  = 2'd0,
        STAT_DROP  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    // One pending press, 51 bits
    typedef struct packed {
        logic [NOTE_W-1:0] note;
        logic              device;
        logic [CHAN_W-1:0] channel;
        logic [VEL_W-1:0]  velocity;
        logic [TIME_W-1:0] stamp;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        status_t            status;
        logic [FREQ_W-1:0]  freq_q16;
        logic [TIME_W-1:0]  start_time;
        logic [TIME_W-1:0]  length;
        logic [LEVEL_W-1:0] level_q16;
        logic               last;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REL_EMIT,
        ST_SHIFT,
        ST_FL_RD,
        ST_FL_EMIT,
        ST_STATUS
    } state_t;

    // Top octave (notes 120..131) frequencies, Q.16
    function automatic logic [FREQ_W-1:0] base_q16(input logic [3:0] semi);
        logic [FREQ_W-1:0] b;
        begin
            unique case (semi)
                4'd0:    b = 30'd548668578;
                4'd1:    b = 30'd581294109;
                4'd2:    b = 30'd615859655;
                4'd3:    b = 30'd652480576;
                4'd4:    b = 30'd691279090;
                4'd5:    b = 30'd732384684;
                4'd6:    b = 30'd775934544;
                4'd7:    b = 30'd822074013;
                4'd8:    b = 30'd870957077;
                4'd9:    b = 30'd922746880;
                4'd10:   b = 30'd977616265;
                4'd11:   b = 30'd1035748353;
                default: b = '0;
            endcase
            return b;
        end
    endfunction

endpackage

// ===== rtl/core/kprp_store.sv =====
module kprp_store #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic [kprp_pkg::ENTRY_W-1:0]  wr_data,
    input  logic                          rd_en,
    input  logic [ADDR_W-1:0]             rd_addr,
    output logic [kprp_pkg::ENTRY_W-1:0]  rd_data
);

    logic [kprp_pkg::ENTRY_W-1:0] mem [DEPTH];
    logic [kprp_pkg::ENTRY_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/kprp_calc.sv =====
module kprp_calc (
    input  kprp_pkg::entry_t                entry,
    input  logic [kprp_pkg::TIME_W-1:0]     release_stamp,
    input  logic                            flush_mode,
    input  logic                            last_in,
    input  logic [kprp_pkg::TIME_W-1:0]     drum_limit,
    input  logic [kprp_pkg::TIME_W-1:0]     drum_short,
    input  logic [kprp_pkg::TIME_W-1:0]     hold_default,
    output kprp_pkg::result_t               result
);

    logic [14:0]                      oct_prod;
    logic [3:0]                       octave;
    logic [3:0]                       semi;
    logic [3:0]                       shift_k;
    logic [kprp_pkg::FREQ_W-1:0]      base;
    logic [kprp_pkg::FREQ_W:0]        round_add;
    logic [kprp_pkg::FREQ_W:0]        round_sum;
    logic [9:0]                       rem_x;
    logic [2:0]                       rem_q;
    logic [kprp_pkg::TIME_W-1:0]      diff;
    logic [kprp_pkg::TIME_W-1:0]      dur;

    // Split note into octave and semitone (n*171 >> 11 equals n/12 for 7-bit n)
    assign oct_prod = 15'(entry.note) * 15'd171;
    assign octave   = oct_prod[14:11];
    assign semi     = 4'(entry.note - 7'(7'(octave) * 7'd12));
    assign shift_k  = 4'd10 - octave;
    assign base     = kprp_pkg::base_q16(semi);

    // Scale the top octave down with round half up
    assign round_add = (shift_k == 4'd0) ? '0 : ((kprp_pkg::FREQ_W+1)'(1) << (shift_k - 4'd1));
    assign round_sum = {1'b0, base} + round_add;

    // v*65536/127 = 516*v + (4*v + 63)/127, remainder part is at most 4
    assign rem_x = {1'b0, entry.velocity, 2'b00} + 10'd63;
    assign rem_q = 3'(rem_x >= 10'd127) + 3'(rem_x >= 10'd254)
                 + 3'(rem_x >= 10'd381) + 3'(rem_x >= 10'd508);

    // Duration: release difference with drum clamp, or flush default
    assign diff = release_stamp - entry.stamp;

    always_comb
    begin
        if (flush_mode)
        begin
            dur = entry.device ? drum_short : hold_default;
        end
        else if (entry.device && (diff > drum_limit))
        begin
            dur = drum_short;
        end
        else
        begin
            dur = diff;
        end
    end

    always_comb
    begin
        result.status     = kprp_pkg::STAT_NOTE;
        result.freq_q16   = kprp_pkg::FREQ_W'(round_sum >> shift_k);
        result.start_time = entry.stamp;
        result.length     = dur;
        result.level_q16  = kprp_pkg::LEVEL_W'(entry.velocity) * 17'd516
                          + kprp_pkg::LEVEL_W'(rem_q);
        result.last       = last_in;
    end

endmodule

// ===== rtl/core/key_press_release_pairer.sv =====
// Key press/release pairer.
// Input stream (s_*): one request per key event; s_tuser holds the opcode
// (press, release, flush), s_tdata the key fields and the time stamp.
// Output stream (m_*): note events; m_tuser holds the status, m_tlast marks
// the final result caused by one request.
// Configuration channel (cfg_*): always ready; write only while idle.
// Operation, with N pending presses and one pending-store read port:
//   press   : no result (a press into a full store gives one drop result).
//   release : the store is scanned one entry per cycle, oldest first; a hit
//             at position h (oldest is 1) is loaded into the output register,
//             then the N-h entries behind it move up; a miss gives no result.
//   flush   : one result per pending entry, each read and then loaded (an
//             empty store gives one status result).
// s_tready is high only while the sequencer is idle.
// A single output register holds each result; while m_tready is low the
// sequencer waits before loading the next one, nothing is dropped.
// Reset empties the pending store (count only) and loads the default
// configuration; no clearing pass is needed.
module key_press_release_pairer #(
    parameter int PENDING_DEPTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [6:0] note, [7] device, [11:8] channel, [18:12] key_velocity,
    // [50:19] stamp, [55:51] zero
    input  logic [55:0]  s_tdata,
    // [1:0] opcode
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [29:0] freq_q16, [61:30] start_time, [93:62] length,
    // [110:94] level_q16, [111] zero
    output logic [111:0] m_tdata,
    // [1:0] status
    output logic [1:0]   m_tuser,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int CNT_W = $clog2(PENDING_DEPTH + 1);

    kprp_pkg::state_t  state_reg, state_next;
    kprp_pkg::entry_t  in_entry;
    kprp_pkg::entry_t  item_reg, item_next;
    kprp_pkg::entry_t  rd_entry;
    kprp_pkg::status_t status_reg, status_next;
    kprp_pkg::result_t out_reg, out_next, calc_result;

    logic [CNT_W-1:0]            count_reg, count_next;
    logic [CNT_W-1:0]            idx_reg, idx_next;
    logic [CNT_W-1:0]            idx_dec;
    logic                        cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]            cmp_idx_reg, cmp_idx_next;
    logic                        pend_wr_reg, pend_wr_next;
    logic [IDX_W-1:0]            pend_dst_reg, pend_dst_next;
    logic                        m_tvalid_reg;

    logic [kprp_pkg::TIME_W-1:0] drum_limit_reg;
    logic [kprp_pkg::TIME_W-1:0] drum_short_reg;
    logic [kprp_pkg::TIME_W-1:0] hold_default_reg;

    logic                        s_accept;
    logic                        out_free;
    logic                        out_load;
    logic                        store_full;
    logic                        match;
    logic                        idx_in_range;
    logic                        flush_last;
    logic                        wr_en;
    logic [IDX_W-1:0]            wr_addr;
    logic [kprp_pkg::ENTRY_W-1:0] wr_data;
    logic                        rd_en;
    logic [IDX_W-1:0]            rd_addr;
    logic [kprp_pkg::ENTRY_W-1:0] rd_data;

    // Unpack the request
    assign in_entry.note     = s_tdata[6:0];
    assign in_entry.device   = s_tdata[7];
    assign in_entry.channel  = s_tdata[11:8];
    assign in_entry.velocity = s_tdata[18:12];
    assign in_entry.stamp    = s_tdata[50:19];

    assign s_tready     = (state_reg == kprp_pkg::ST_IDLE);
    assign s_accept     = s_tvalid && s_tready;
    assign out_free     = !m_tvalid_reg || m_tready;
    assign store_full   = (count_reg >= CNT_W'(PENDING_DEPTH));
    assign idx_in_range = (idx_reg < count_reg);
    assign idx_dec      = idx_reg - CNT_W'(1);
    assign flush_last   = (CNT_W'(idx_reg + CNT_W'(1)) == count_reg);
    assign rd_entry     = kprp_pkg::entry_t'(rd_data);

    // Compare the entry read last cycle with the released key
    assign match = cmp_valid_reg
                && (rd_entry.note == item_reg.note)
                && (rd_entry.device == item_reg.device)
                && (rd_entry.channel == item_reg.channel);

    kprp_store #(
        .DEPTH  (PENDING_DEPTH),
        .ADDR_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    kprp_calc u_calc (
        .entry         (rd_entry),
        .release_stamp (item_reg.stamp),
        .flush_mode    (state_reg == kprp_pkg::ST_FL_EMIT),
        .last_in       ((state_reg == kprp_pkg::ST_FL_EMIT) ? flush_last : 1'b1),
        .drum_limit    (drum_limit_reg),
        .drum_short    (drum_short_reg),
        .hold_default  (hold_default_reg),
        .result        (calc_result)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kprp_pkg::ST_IDLE:
            begin
                if (s_accept)
                begin
                    case (s_tuser)
                        kprp_pkg::OP_PRESS:
                            state_next = store_full ? kprp_pkg::ST_STATUS : kprp_pkg::ST_IDLE;
                        kprp_pkg::OP_RELEASE:
                            state_next = kprp_pkg::ST_SCAN;
                        kprp_pkg::OP_FLUSH:
                            state_next = (count_reg == '0) ? kprp_pkg::ST_STATUS
                                                           : kprp_pkg::ST_FL_RD;
                        default:
                            state_next = kprp_pkg::ST_IDLE;
                    endcase
                end
            end
            kprp_pkg::ST_SCAN:
            begin
                if (match)
                begin
                    state_next = kprp_pkg::ST_REL_EMIT;
                end
                else if (!idx_in_range)
                begin
                    state_next = kprp_pkg::ST_IDLE;
                end
            end
            kprp_pkg::ST_REL_EMIT:
            begin
                if (out_free)
                begin
                    state_next = kprp_pkg::ST_SHIFT;
                end
            end
            kprp_pkg::ST_SHIFT:
            begin
                if (!idx_in_range && !pend_wr_reg)
                begin
                    state_next = kprp_pkg::ST_IDLE;
                end
            end
            kprp_pkg::ST_FL_RD:
            begin
                state_next = kprp_pkg::ST_FL_EMIT;
            end
            kprp_pkg::ST_FL_EMIT:
            begin
                if (out_free)
                begin
                    state_next = flush_last ? kprp_pkg::ST_IDLE : kprp_pkg::ST_FL_RD;
                end
            end
            kprp_pkg::ST_STATUS:
            begin
                if (out_free)
                begin
                    state_next = kprp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kprp_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: store access, output load, register updates
    always_comb
    begin
        item_next      = item_reg;
        status_next    = status_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        pend_wr_next   = pend_wr_reg;
        pend_dst_next  = pend_dst_reg;
        wr_en          = 1'b0;
        wr_addr        = count_reg[IDX_W-1:0];
        wr_data        = in_entry;
        rd_en          = 1'b0;
        rd_addr        = idx_reg[IDX_W-1:0];
        out_load       = 1'b0;

        unique case (state_reg)
            kprp_pkg::ST_IDLE:
            begin
                if (s_accept)
                begin
                    item_next      = in_entry;
                    idx_next       = '0;
                    cmp_valid_next = 1'b0;
                    pend_wr_next   = 1'b0;
                    case (s_tuser)
                        kprp_pkg::OP_PRESS:
                        begin
                            if (store_full)
                            begin
                                status_next = kprp_pkg::STAT_DROP;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        kprp_pkg::OP_FLUSH:
                        begin
                            status_next = kprp_pkg::STAT_EMPTY;
                        end
                        default:
                        begin
                            status_next = status_reg;
                        end
                    endcase
                end
            end
            kprp_pkg::ST_SCAN:
            begin
                // Issue the next read unless the current entry hit
                if (!match)
                begin
                    if (idx_in_range)
                    begin
                        rd_en          = 1'b1;
                        cmp_valid_next = 1'b1;
                        cmp_idx_next   = idx_reg[IDX_W-1:0];
                        idx_next       = idx_reg + CNT_W'(1);
                    end
                    else
                    begin
                        cmp_valid_next = 1'b0;
                    end
                end
            end
            kprp_pkg::ST_REL_EMIT:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    cmp_valid_next = 1'b0;
                    idx_next       = CNT_W'(cmp_idx_reg) + CNT_W'(1);
                end
            end
            kprp_pkg::ST_SHIFT:
            begin
                // Move entries behind the hit up by one, each read in the cycle before its write
                if (pend_wr_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = pend_dst_reg;
                    wr_data = rd_data;
                end
                if (idx_in_range)
                begin
                    rd_en         = 1'b1;
                    pend_wr_next  = 1'b1;
                    pend_dst_next = idx_dec[IDX_W-1:0];
                    idx_next      = idx_reg + CNT_W'(1);
                end
                else
                begin
                    pend_wr_next = 1'b0;
                    if (!pend_wr_reg)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            kprp_pkg::ST_FL_RD:
            begin
                rd_en = 1'b1;
            end
            kprp_pkg::ST_FL_EMIT:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    idx_next = idx_reg + CNT_W'(1);
                    if (flush_last)
                    begin
                        count_next = '0;
                    end
                end
            end
            kprp_pkg::ST_STATUS:
            begin
                out_load = out_free;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    // Select the result to load
    always_comb
    begin
        if (state_reg == kprp_pkg::ST_STATUS)
        begin
            out_next        = '0;
            out_next.status = status_reg;
            out_next.last   = 1'b1;
        end
        else
        begin
            out_next = calc_result;
        end
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kprp_pkg::ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            pend_wr_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            cmp_valid_reg <= cmp_valid_next;
            pend_wr_reg   <= pend_wr_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        status_reg   <= status_next;
        cmp_idx_reg  <= cmp_idx_next;
        pend_dst_reg <= pend_dst_next;
    end

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drum_limit_reg   <= kprp_pkg::DRUM_LIMIT_RST;
            drum_short_reg   <= kprp_pkg::DRUM_SHORT_RST;
            hold_default_reg <= kprp_pkg::HOLD_DEFAULT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                kprp_pkg::CFG_DRUM_LIMIT:   drum_limit_reg   <= cfg_data;
                kprp_pkg::CFG_DRUM_SHORT:   drum_short_reg   <= cfg_data;
                kprp_pkg::CFG_HOLD_DEFAULT: hold_default_reg <= cfg_data;
                default:                    drum_limit_reg   <= drum_limit_reg;
            endcase
        end
    end

    // Output register: load a new result, drop the valid once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {1'b0, out_reg.level_q16, out_reg.length,
                       out_reg.start_time, out_reg.freq_q16};

    // Pending count never passes the store depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(PENDING_DEPTH))
        else $error("pending count beyond store depth");

    // Only entries below the count are ever read
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (CNT_W'(rd_addr) < count_reg))
        else $error("read of an entry outside the pending range");

    // Writes land at or below the count
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (CNT_W'(wr_addr) <= count_reg))
        else $error("write beyond the end of the pending range");

    // A result is loaded only into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!m_tvalid_reg || m_tready))
        else $error("output register overwritten while stalled");

    // No move write is left over when a new request can enter
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !pend_wr_reg)
        else $error("store move still pending while idle");

endmodule
